// ===== hw/rtl/mwa_pkg.sv =====
// shared constants, types and state encoding for the moving window average block
package mwa_pkg;

	localparam int DEF_MAX_WINDOW  = 16;
	localparam int DEF_SAMPLE_BITS = 16;

	// fill count and window size fields are fixed at five bits
	localparam int COUNT_BITS = 5;
	localparam int WIN_BITS   = 5;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic                REG_WINDOW_SIZE = 1'b0;
	localparam logic [WIN_BITS-1:0] WINDOW_RESET    = WIN_BITS'(16);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_START,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic upd;
		logic clear;
		logic cfg_wr;
	} ring_ctl_t;

endpackage

// ===== hw/rtl/mwa_ifs.sv =====
// valid/ready channel interfaces for samples and results
interface mwa_in_if #(
	parameter int SAMPLE_BITS = mwa_pkg::DEF_SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic                          func;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output func, output sample, input ready);
	modport sink (input valid, input func, input sample, output ready);
endinterface

interface mwa_out_if #(
	parameter int SAMPLE_BITS = mwa_pkg::DEF_SAMPLE_BITS
);
	logic                              valid;
	logic                              ready;
	logic signed [SAMPLE_BITS-1:0]     average;
	logic [mwa_pkg::COUNT_BITS-1:0]    fill_count;

	modport source (output valid, output average, output fill_count, input ready);
	modport sink (input valid, input average, input fill_count, output ready);
endinterface

// ===== hw/rtl/moving_window_average_core.sv =====
// moving window average: ring of samples, running sum and serial divide per item
// each item passes through the update, start and divide states, then waits in done until the output register is free
// a new item is taken only in the idle state, so the item rate is bounded by the bit-serial
//   divider which produces one quotient bit per cycle over SAMPLE_BITS + 4 bits
// the output register lets the next item be taken while a result waits
// reset: window empty, window size 16, no result pending; ring contents are not cleared
module moving_window_average_core #(
	parameter int MAX_WINDOW  = mwa_pkg::DEF_MAX_WINDOW,
	parameter int SAMPLE_BITS = mwa_pkg::DEF_SAMPLE_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	mwa_in_if.sink                       sample_ch,
	mwa_out_if.source                    result_ch,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mwa_pkg::PADDR_W-1:0]  paddr,
	input  logic [mwa_pkg::PDATA_W-1:0]  pwdata,
	output logic [mwa_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import mwa_pkg::*;

	localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;
	localparam int MAG_W = SUM_W - 1;

	state_t state_q;
	state_t state_nxt;

	logic [WIN_BITS-1:0]           window_size_q;
	logic [COUNT_BITS-1:0]         win_eff;
	logic                          func_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_average_q;
	logic [COUNT_BITS-1:0]         out_fill_q;

	ring_ctl_t                ring_ctl;
	logic signed [SUM_W-1:0]  sum;
	logic [COUNT_BITS-1:0]    count;
	logic [SUM_W-1:0]         sum_abs;

	logic             div_start;
	logic             div_busy;
	logic [MAG_W-1:0] quotient;
	logic [MAG_W-1:0] avg_full;

	logic in_xfer;
	logic out_xfer;
	logic cfg_wr;
	logic load;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[PADDR_W-1] == REG_WINDOW_SIZE);

	always_comb begin
		prdata = '0;
		if (paddr[PADDR_W-1] == REG_WINDOW_SIZE) begin
			prdata[WIN_BITS-1:0] = window_size_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_RESET;
		end else if (cfg_wr) begin
			window_size_q <= pwdata[WIN_BITS-1:0];
		end
	end

	// out-of-range sizes clamp to 1..MAX_WINDOW
	always_comb begin
		if (window_size_q == '0) begin
			win_eff = COUNT_BITS'(1);
		end else if (int'(window_size_q) > MAX_WINDOW) begin
			win_eff = COUNT_BITS'(MAX_WINDOW);
		end else begin
			win_eff = COUNT_BITS'(window_size_q);
		end
	end

	assign in_xfer  = sample_ch.valid && sample_ch.ready;
	assign out_xfer = result_ch.valid && result_ch.ready;

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_q   <= sample_ch.func;
			sample_q <= sample_ch.sample;
		end
	end

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_nxt = ST_UPDATE;
				end
			end
			ST_UPDATE: state_nxt = ST_START;
			ST_START:  state_nxt = ST_DIV;
			ST_DIV: begin
				if (!div_busy) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || result_ch.ready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		sample_ch.ready = (state_q == ST_IDLE);
		ring_ctl.upd    = (state_q == ST_UPDATE);
		ring_ctl.clear  = func_q;
		ring_ctl.cfg_wr = cfg_wr;
		div_start       = (state_q == ST_START);
		load            = (state_q == ST_DONE) && (!out_valid_q || result_ch.ready);
	end

	mwa_ring #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ring_ctl),
		.sample (sample_q),
		.win    (win_eff),
		.sum    (sum),
		.count  (count)
	);

	// magnitude of the sum always fits one bit narrower than the sum
	assign sum_abs = sum[SUM_W-1] ? (-sum) : sum;

	mwa_div #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_abs[MAG_W-1:0]),
		.divisor  (count),
		.busy     (div_busy),
		.quotient (quotient)
	);

	// truncation toward zero: divide magnitudes, then restore the sign
	assign avg_full = sum[SUM_W-1] ? (-quotient) : quotient;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_average_q <= (count == '0) ? '0 : avg_full[SAMPLE_BITS-1:0];
			out_fill_q    <= count;
		end
	end

	assign result_ch.valid      = out_valid_q;
	assign result_ch.average    = out_average_q;
	assign result_ch.fill_count = out_fill_q;

	// checks
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		sample_ch.ready |-> !div_busy)
		else $error("input taken while divider still running");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= win_eff)
		else $error("fill count above effective window");

	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> (div_busy && state_q == ST_DIV))
		else $error("divider did not start");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(result_ch.valid && !result_ch.ready) |=> result_ch.valid)
		else $error("pending result dropped");

endmodule

// ===== hw/rtl/mwa_ring.sv =====
// sample ring memory with running sum, fill count and write pointer
module mwa_ring #(
	parameter int MAX_WINDOW  = mwa_pkg::DEF_MAX_WINDOW,
	parameter int SAMPLE_BITS = mwa_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  mwa_pkg::ring_ctl_t                                 ctl,
	input  logic signed [SAMPLE_BITS-1:0]                      sample,
	input  logic [mwa_pkg::COUNT_BITS-1:0]                     win,
	output logic signed [SAMPLE_BITS+mwa_pkg::COUNT_BITS-1:0]  sum,
	output logic [mwa_pkg::COUNT_BITS-1:0]                     count
);
	import mwa_pkg::*;

	localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;
	localparam int PTR_W = $clog2(MAX_WINDOW);
	localparam int CMP_W = (PTR_W + 1 > COUNT_BITS) ? PTR_W + 1 : COUNT_BITS;

	logic signed [SAMPLE_BITS-1:0] store_mem [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] rdata_q;
	logic [PTR_W-1:0]              ptr_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic [COUNT_BITS-1:0]         count_q;

	logic                    full;
	logic                    wrap;
	logic [PTR_W:0]          ptr_inc;
	logic signed [SUM_W-1:0] add_ext;
	logic signed [SUM_W-1:0] old_ext;
	logic signed [SUM_W-1:0] sum_nxt;

	// read port follows the pointer every cycle, so the slot about to be
	// overwritten is already in rdata_q when an item is applied
	always_ff @(posedge clk) begin
		rdata_q <= store_mem[ptr_q];
	end

	always_ff @(posedge clk) begin
		if (ctl.upd && !ctl.clear) begin
			store_mem[ptr_q] <= sample;
		end
	end

	always_comb begin
		full    = (count_q >= win);
		ptr_inc = {1'b0, ptr_q} + (PTR_W+1)'(1);
		wrap    = (CMP_W'(ptr_inc) >= CMP_W'(win));
		add_ext = SUM_W'(sample);
		old_ext = full ? SUM_W'(rdata_q) : '0;
		sum_nxt = sum_q + add_ext - old_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			ptr_q   <= '0;
		end else if (ctl.cfg_wr || (ctl.upd && ctl.clear)) begin
			sum_q   <= '0;
			count_q <= '0;
			ptr_q   <= '0;
		end else if (ctl.upd) begin
			sum_q <= sum_nxt;
			if (!full) begin
				count_q <= count_q + COUNT_BITS'(1);
			end
			ptr_q <= wrap ? '0 : ptr_inc[PTR_W-1:0];
		end
	end

	assign sum   = sum_q;
	assign count = count_q;

endmodule

// ===== hw/rtl/mwa_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module mwa_div #(
	parameter int SAMPLE_BITS = mwa_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	input  logic [SAMPLE_BITS+mwa_pkg::COUNT_BITS-2:0]  dividend,
	input  logic [mwa_pkg::COUNT_BITS-1:0]              divisor,
	output logic                                        busy,
	output logic [SAMPLE_BITS+mwa_pkg::COUNT_BITS-2:0]  quotient
);
	import mwa_pkg::*;

	localparam int MAG_W = SAMPLE_BITS + COUNT_BITS - 1;
	localparam int CNT_W = $clog2(MAG_W + 1);

	logic [MAG_W-1:0]      quo_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [COUNT_BITS-1:0] div_q;
	logic [CNT_W-1:0]      steps_q;

	logic [COUNT_BITS:0] trial;
	logic [COUNT_BITS:0] diff;
	logic                ge;

	// dividend bits leave at the top of quo_q while quotient bits enter at the bottom
	always_comb begin
		trial = {rem_q, quo_q[MAG_W-1]};
		diff  = trial - {1'b0, div_q};
		ge    = (trial >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
		end else if (start) begin
			steps_q <= CNT_W'(MAG_W);
		end else if (steps_q != '0) begin
			steps_q <= steps_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (steps_q != '0) begin
			quo_q <= {quo_q[MAG_W-2:0], ge};
			rem_q <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
		end
	end

	assign busy     = (steps_q != '0);
	assign quotient = quo_q;

endmodule
